// ===== src/nid_pkg.sv =====
// Shared types, constants and codes of the neutral ionization deposit block.
package nid_pkg;

    // Default grid size along each axis.
    localparam int GRID_NX_DEF = 32;
    localparam int GRID_NY_DEF = 32;
    localparam int GRID_NZ_DEF = 32;

    // Output queue depth; it also bounds the transactions in flight.
    localparam int OUT_DEPTH = 8;

    // Configuration port geometry.
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // Stream widths.
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    // Cell and weight arithmetic, all Q2.16.
    localparam int CELL_W = 18;
    localparam logic [CELL_W-1:0] CELL_MAX     = 18'h3FFFF;
    localparam logic [CELL_W-1:0] EMIT_MIN     = 18'd66192;
    localparam logic [CELL_W-1:0] ONE_Q16      = 18'd65536;
    localparam logic [16:0]       RETIRE_LIMIT = 17'd655;
    localparam logic [17:0]       RETIRED_CODE = 18'h30000;

    typedef enum logic [1:0] {
        ST_PROCESSED = 2'd0,
        ST_INACTIVE  = 2'd1,
        ST_SHADOWED  = 2'd2,
        ST_OUTSIDE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_IONIZE_FRACTION = 3'd0,
        REG_PLANET_X        = 3'd1,
        REG_PLANET_Y        = 3'd2,
        REG_PLANET_Z        = 3'd3,
        REG_RADIUS_SQUARED  = 3'd4,
        REG_INV_CELL_X      = 3'd5,
        REG_INV_CELL_Y      = 3'd6,
        REG_INV_CELL_Z      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]        ionize_fraction;
        logic signed [31:0] planet_x;
        logic signed [31:0] planet_y;
        logic signed [31:0] planet_z;
        logic [47:0]        radius_squared;
        logic [23:0]        inv_cell_x;
        logic [23:0]        inv_cell_y;
        logic [23:0]        inv_cell_z;
    } cfg_t;

    // One particle after index and distance work, ready for the cell update.
    typedef struct packed {
        logic        inactive;
        logic        px_gt;
        logic        outside;
        logic [65:0] sq_y;
        logic [65:0] sq_z;
        logic [16:0] dw;
        logic [17:0] neww;
        logic [17:0] w_in;
    } calc_t;

    typedef struct packed {
        logic [31:0] ion_total;
        status_t     status;
        logic        emit_ion;
        logic [17:0] new_weight;
    } res_t;

endpackage

// ===== src/nid_cfg.sv =====
// APB-style configuration registers of the neutral ionization deposit block.
module nid_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nid_pkg::PADDR_W-1:0]  paddr,
    input  logic [nid_pkg::PDATA_W-1:0]  pwdata,
    output logic [nid_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output nid_pkg::cfg_t                cfg
);

    nid_pkg::cfg_t    cfg_reg;
    nid_pkg::reg_idx_t idx;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = nid_pkg::reg_idx_t'(paddr[nid_pkg::PADDR_W-1:3]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ionize_fraction <= '0;
            cfg_reg.planet_x        <= '0;
            cfg_reg.planet_y        <= '0;
            cfg_reg.planet_z        <= '0;
            cfg_reg.radius_squared  <= '0;
            cfg_reg.inv_cell_x      <= 24'd65536;
            cfg_reg.inv_cell_y      <= 24'd65536;
            cfg_reg.inv_cell_z      <= 24'd65536;
        end else if (wr) begin
            case (idx)
                nid_pkg::REG_IONIZE_FRACTION: cfg_reg.ionize_fraction <= pwdata[15:0];
                nid_pkg::REG_PLANET_X:        cfg_reg.planet_x        <= pwdata[31:0];
                nid_pkg::REG_PLANET_Y:        cfg_reg.planet_y        <= pwdata[31:0];
                nid_pkg::REG_PLANET_Z:        cfg_reg.planet_z        <= pwdata[31:0];
                nid_pkg::REG_RADIUS_SQUARED:  cfg_reg.radius_squared  <= pwdata[47:0];
                nid_pkg::REG_INV_CELL_X:      cfg_reg.inv_cell_x      <= pwdata[23:0];
                nid_pkg::REG_INV_CELL_Y:      cfg_reg.inv_cell_y      <= pwdata[23:0];
                nid_pkg::REG_INV_CELL_Z:      cfg_reg.inv_cell_z      <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            nid_pkg::REG_IONIZE_FRACTION: prdata = {48'd0, cfg_reg.ionize_fraction};
            nid_pkg::REG_PLANET_X:        prdata = {32'd0, cfg_reg.planet_x};
            nid_pkg::REG_PLANET_Y:        prdata = {32'd0, cfg_reg.planet_y};
            nid_pkg::REG_PLANET_Z:        prdata = {32'd0, cfg_reg.planet_z};
            nid_pkg::REG_RADIUS_SQUARED:  prdata = {16'd0, cfg_reg.radius_squared};
            nid_pkg::REG_INV_CELL_X:      prdata = {40'd0, cfg_reg.inv_cell_x};
            nid_pkg::REG_INV_CELL_Y:      prdata = {40'd0, cfg_reg.inv_cell_y};
            nid_pkg::REG_INV_CELL_Z:      prdata = {40'd0, cfg_reg.inv_cell_z};
            default:                      prdata = '0;
        endcase
    end

endmodule

// ===== src/nid_ram.sv =====
// Single-write, single-read synchronous memory holding the cell weights.
module nid_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int DW    = 18
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== src/nid_calc.sv =====
// Front pipeline: cell index, shadow distance terms and weight loss per particle.
module nid_calc #(
    parameter int GRID_NX = nid_pkg::GRID_NX_DEF,
    parameter int GRID_NY = nid_pkg::GRID_NY_DEF,
    parameter int GRID_NZ = nid_pkg::GRID_NZ_DEF,
    parameter int AW      = $clog2(GRID_NX * GRID_NY * GRID_NZ)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [17:0]        particle_weight,
    input  nid_pkg::cfg_t      cfg,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    output logic               item_valid,
    output nid_pkg::calc_t     item,
    output logic [AW-1:0]      item_addr
);

    localparam int XW = $clog2(GRID_NX);
    localparam int YW = $clog2(GRID_NY);
    localparam int ZW = $clog2(GRID_NZ);

    // Stage 1: registered particle.
    logic               s1_valid_reg;
    logic signed [31:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [17:0]        s1_w_reg;

    logic signed [56:0] prod_x, prod_y, prod_z;
    logic signed [32:0] dy_s, dz_s;
    logic [32:0]        dy, dz;
    logic [32:0]        dw_full;
    logic               px_gt;

    // Stage 2: products and differences.
    logic        s2_valid_reg;
    logic [17:0] s2_w_reg;
    logic        s2_px_gt_reg;
    logic [32:0] s2_dy_reg, s2_dz_reg;
    logic [16:0] s2_dw_reg;
    logic        s2_neg_x_reg, s2_neg_y_reg, s2_neg_z_reg;
    logic [23:0] s2_hi_x_reg, s2_hi_y_reg, s2_hi_z_reg;

    logic        out_x, out_y, out_z;
    logic [AW-1:0] addr;
    logic [16:0] rem;
    nid_pkg::calc_t item_next;

    // Stage 3 outputs.
    logic           s3_valid_reg;
    nid_pkg::calc_t s3_item_reg;
    logic [AW-1:0]  s3_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
        s1_px_reg <= pos_x;
        s1_py_reg <= pos_y;
        s1_pz_reg <= pos_z;
        s1_w_reg  <= particle_weight;

        s2_w_reg     <= s1_w_reg;
        s2_px_gt_reg <= px_gt;
        s2_dy_reg    <= dy;
        s2_dz_reg    <= dz;
        s2_dw_reg    <= dw_full[32:16];
        s2_neg_x_reg <= prod_x[56];
        s2_neg_y_reg <= prod_y[56];
        s2_neg_z_reg <= prod_z[56];
        s2_hi_x_reg  <= prod_x[55:32];
        s2_hi_y_reg  <= prod_y[55:32];
        s2_hi_z_reg  <= prod_z[55:32];

        s3_item_reg <= item_next;
        s3_addr_reg <= addr;
    end

    // Stage 1 arithmetic: Q16.16 times Q8.16, distance differences, weight loss.
    always_comb begin
        prod_x  = s1_px_reg * $signed({1'b0, cfg.inv_cell_x});
        prod_y  = s1_py_reg * $signed({1'b0, cfg.inv_cell_y});
        prod_z  = s1_pz_reg * $signed({1'b0, cfg.inv_cell_z});
        dy_s    = {s1_py_reg[31], s1_py_reg} - {cfg.planet_y[31], cfg.planet_y};
        dz_s    = {s1_pz_reg[31], s1_pz_reg} - {cfg.planet_z[31], cfg.planet_z};
        dy      = dy_s[32] ? 33'(-dy_s) : 33'(dy_s);
        dz      = dz_s[32] ? 33'(-dz_s) : 33'(dz_s);
        px_gt   = s1_px_reg > cfg.planet_x;
        dw_full = {16'd0, s1_w_reg[16:0]} * {17'd0, cfg.ionize_fraction};
    end

    // Stage 2: grid bounds, cell address, squares and the remaining weight.
    always_comb begin
        out_x = s2_neg_x_reg || (s2_hi_x_reg >= 24'(GRID_NX));
        out_y = s2_neg_y_reg || (s2_hi_y_reg >= 24'(GRID_NY));
        out_z = s2_neg_z_reg || (s2_hi_z_reg >= 24'(GRID_NZ));
        addr  = AW'(s2_hi_x_reg[XW-1:0])
              + AW'(GRID_NX) * (AW'(s2_hi_y_reg[YW-1:0])
              + AW'(GRID_NY) * AW'(s2_hi_z_reg[ZW-1:0]));
        rem   = s2_w_reg[16:0] - s2_dw_reg;

        item_next.inactive = s2_w_reg[17];
        item_next.px_gt    = s2_px_gt_reg;
        item_next.outside  = out_x || out_y || out_z;
        item_next.sq_y     = {33'd0, s2_dy_reg} * {33'd0, s2_dy_reg};
        item_next.sq_z     = {33'd0, s2_dz_reg} * {33'd0, s2_dz_reg};
        item_next.dw       = s2_dw_reg;
        item_next.neww     = (rem <= nid_pkg::RETIRE_LIMIT) ? nid_pkg::RETIRED_CODE
                                                            : {1'b0, rem};
        item_next.w_in     = s2_w_reg;
    end

    // The cell read is issued from stage 2 so its data lines up with stage 3.
    assign rd_en      = s2_valid_reg;
    assign rd_addr    = addr;
    assign item_valid = s3_valid_reg;
    assign item       = s3_item_reg;
    assign item_addr  = s3_addr_reg;

endmodule

// ===== src/nid_acc.sv =====
// Cell read-modify-write with forwarding, ion counter and post-reset clearing sweep.
module nid_acc #(
    parameter int CELLS = nid_pkg::GRID_NX_DEF * nid_pkg::GRID_NY_DEF * nid_pkg::GRID_NZ_DEF,
    parameter int AW    = $clog2(CELLS)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       item_valid,
    input  nid_pkg::calc_t             item,
    input  logic [AW-1:0]              item_addr,
    input  logic [47:0]                radius_squared,
    input  logic [nid_pkg::CELL_W-1:0] rd_data,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [nid_pkg::CELL_W-1:0] wr_data,
    output logic                       res_valid,
    output nid_pkg::res_t              res,
    output logic                       busy
);

    logic                       clr_busy_reg;
    logic [AW-1:0]              clr_cnt_reg;

    logic                       fwd_we_reg;
    logic [AW-1:0]              fwd_addr_reg;
    logic [nid_pkg::CELL_W-1:0] fwd_data_reg;
    logic [31:0]                ions_reg;
    logic [31:0]                ions_next;

    logic [66:0]                dist_sum;
    logic                       shadow;
    nid_pkg::status_t           status;
    logic [nid_pkg::CELL_W-1:0] cell_val;
    logic [nid_pkg::CELL_W:0]   acc_sum;
    logic [nid_pkg::CELL_W-1:0] acc_sat;
    logic                       emit_hit;
    logic [nid_pkg::CELL_W-1:0] new_cell;
    logic                       do_upd;

    always_comb begin
        dist_sum = {1'b0, item.sq_y} + {1'b0, item.sq_z};
        shadow   = item.px_gt && (dist_sum[66:16] < {3'd0, radius_squared});
        if (item.inactive) begin
            status = nid_pkg::ST_INACTIVE;
        end else if (shadow) begin
            status = nid_pkg::ST_SHADOWED;
        end else if (item.outside) begin
            status = nid_pkg::ST_OUTSIDE;
        end else begin
            status = nid_pkg::ST_PROCESSED;
        end
        do_upd = item_valid && (status == nid_pkg::ST_PROCESSED);

        // The previous update wrote at the edge that launched this read.
        cell_val = (fwd_we_reg && (fwd_addr_reg == item_addr)) ? fwd_data_reg : rd_data;
        acc_sum  = {1'b0, cell_val} + {2'b0, item.dw};
        acc_sat  = acc_sum[nid_pkg::CELL_W] ? nid_pkg::CELL_MAX
                                            : acc_sum[nid_pkg::CELL_W-1:0];
        emit_hit = acc_sat >= nid_pkg::EMIT_MIN;
        new_cell = emit_hit ? (acc_sat - nid_pkg::ONE_Q16) : acc_sat;

        ions_next = ions_reg + {31'd0, do_upd && emit_hit};

        res.new_weight = (status == nid_pkg::ST_PROCESSED) ? item.neww : item.w_in;
        res.emit_ion   = do_upd && emit_hit;
        res.status     = status;
        res.ion_total  = ions_next;

        if (clr_busy_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end else begin
            wr_en   = do_upd;
            wr_addr = item_addr;
            wr_data = new_cell;
        end
    end

    assign res_valid = item_valid;
    assign busy      = clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            fwd_we_reg   <= 1'b0;
            ions_reg     <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(CELLS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            fwd_we_reg <= do_upd;
            ions_reg   <= ions_next;
        end
        fwd_addr_reg <= item_addr;
        fwd_data_reg <= new_cell;
    end

endmodule

// ===== src/nid_ofifo.sv =====
// Output queue of results with a credit count covering transactions still in flight.
module nid_ofifo #(
    parameter int DEPTH = nid_pkg::OUT_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_fire,
    input  logic          push,
    input  nid_pkg::res_t push_data,
    output logic          m_valid,
    input  logic          m_ready,
    output nid_pkg::res_t m_data,
    output logic          credit
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    nid_pkg::res_t q_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;

    assign m_valid  = occ_reg != '0;
    assign m_data   = q_reg[rd_ptr_reg];
    assign pop      = m_valid && m_ready;
    assign credit   = cnt_reg < CW'(DEPTH);
    assign occ_next = occ_reg + CW'(push) - CW'(pop);
    assign cnt_next = cnt_reg + CW'(s_fire) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            occ_reg <= occ_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/neutral_ionization_deposit.sv =====
// Top level of the neutral ionization deposit block.
//
// Each slave-side stream transaction carries one neutral particle. The block
// decides whether it is inactive, in the planet's shadow or outside the grid,
// and otherwise takes a fraction of its weight and adds it to one cell of a
// 3D grid held in a synchronous memory. Every input transaction yields exactly
// one master-side transaction with the new weight, an ion-emit flag, the
// running ion count, and the status code on m_tuser.
// Throughput is one particle per cycle while s_tready is high. The cell
// memory is read in the second pipeline stage and written back in the third;
// an update to the same cell by the directly preceding particle is forwarded
// from a bypass register, so back-to-back hits on one cell need no stall.
// A result passes the stage registers and the output queue before m_tvalid.
// An eight-entry output queue decouples the two sides: s_tready stays high as
// long as fewer than eight transactions are accepted but not yet delivered, so
// a stalled receiver throttles the input only once eight are outstanding.
// After reset the block sweeps the whole grid to zero, one cell per cycle,
// all GRID_NX*GRID_NY*GRID_NZ cells (32768 with the default sizes); s_tready is
// low during the sweep while configuration writes are taken as usual.
// Configuration registers sit at byte address 8*i on the APB-style port.
module neutral_ionization_deposit #(
    parameter int GRID_NX = nid_pkg::GRID_NX_DEF,
    parameter int GRID_NY = nid_pkg::GRID_NY_DEF,
    parameter int GRID_NZ = nid_pkg::GRID_NZ_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Fields from bit 0: pos_x[31:0], pos_y[63:32], pos_z[95:64],
    // particle_weight[113:96], zero padding.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nid_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: new_weight[17:0], emit_ion[18], ion_total[50:19],
    // zero padding.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nid_pkg::M_TDATA_W-1:0]  m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [nid_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nid_pkg::PADDR_W-1:0]    paddr,
    input  logic [nid_pkg::PDATA_W-1:0]    pwdata,
    output logic [nid_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int CELLS = GRID_NX * GRID_NY * GRID_NZ;
    localparam int AW    = $clog2(CELLS);

    nid_pkg::cfg_t  cfg;
    nid_pkg::calc_t item;
    nid_pkg::res_t  res;
    nid_pkg::res_t  out_res;

    logic                       s_fire;
    logic                       credit;
    logic                       busy;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [nid_pkg::CELL_W-1:0] rd_data;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [nid_pkg::CELL_W-1:0] wr_data;
    logic                       item_valid;
    logic [AW-1:0]              item_addr;
    logic                       res_valid;

    // Input is taken only when the queue has room for its result and the
    // clearing sweep is done.
    assign s_tready = credit && !busy;
    assign s_fire   = s_tvalid && s_tready;

    nid_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nid_calc #(
        .GRID_NX (GRID_NX),
        .GRID_NY (GRID_NY),
        .GRID_NZ (GRID_NZ),
        .AW      (AW)
    ) u_calc (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_fire),
        .pos_x           (s_tdata[31:0]),
        .pos_y           (s_tdata[63:32]),
        .pos_z           (s_tdata[95:64]),
        .particle_weight (s_tdata[113:96]),
        .cfg             (cfg),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .item_valid      (item_valid),
        .item            (item),
        .item_addr       (item_addr)
    );

    nid_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (nid_pkg::CELL_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nid_acc #(
        .CELLS (CELLS),
        .AW    (AW)
    ) u_acc (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (item_valid),
        .item           (item),
        .item_addr      (item_addr),
        .radius_squared (cfg.radius_squared),
        .rd_data        (rd_data),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .res_valid      (res_valid),
        .res            (res),
        .busy           (busy)
    );

    nid_ofifo #(
        .DEPTH (nid_pkg::OUT_DEPTH)
    ) u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_fire    (s_fire),
        .push      (res_valid),
        .push_data (res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_res),
        .credit    (credit)
    );

    // Pack the result fields onto the master-side stream.
    assign m_tdata = {5'd0, out_res.ion_total, out_res.emit_ion, out_res.new_weight};
    assign m_tuser = out_res.status;

endmodule
